// ----- rtl/qrm_pkg.sv -----
// Package for the quaternion to rotation matrix pipeline.
// Widths, payload types and element indices shared by all stage modules.
// No dependencies.
`default_nettype none

package qrm_pkg;

    localparam int IN_W      = 16;  // quaternion component width
    localparam int OUT_W     = 16;  // matrix element width
    localparam int PROD_W    = 32;  // 16x16 product, sign-extended
    localparam int SUM_W     = 33;  // sum of four squares, unsigned
    localparam int NUM_W     = 34;  // signed numerator, 2*(ab-cd) needs 34 bits
    localparam int EPS_W     = 16;
    localparam int EPS_SQ_W  = 32;
    localparam int D_W       = SUM_W + 1;  // divisor 2*S
    localparam int N_ELEM    = 9;

    localparam int E00 = 0;
    localparam int E01 = 1;
    localparam int E02 = 2;
    localparam int E10 = 3;
    localparam int E11 = 4;
    localparam int E12 = 5;
    localparam int E20 = 6;
    localparam int E21 = 7;
    localparam int E22 = 8;

    typedef logic signed [IN_W-1:0]  comp_t;
    typedef logic signed [NUM_W-1:0] num_t;
    typedef logic [OUT_W-1:0]        elem_t;

    typedef struct packed {
        logic [PROD_W-1:0]        xx;
        logic [PROD_W-1:0]        yy;
        logic [PROD_W-1:0]        zz;
        logic [PROD_W-1:0]        ww;
        logic signed [PROD_W-1:0] xy;
        logic signed [PROD_W-1:0] xz;
        logic signed [PROD_W-1:0] yz;
        logic signed [PROD_W-1:0] wx;
        logic signed [PROD_W-1:0] wy;
        logic signed [PROD_W-1:0] wz;
    } prod_t;

    typedef struct packed {
        logic [SUM_W-1:0] s;
        logic             degen;
    } norm_t;

endpackage

`default_nettype wire

// ----- rtl/qrm_mult.sv -----
// Stage 1: the ten component products.
// Depends on qrm_pkg.
`default_nettype none

module qrm_mult
    import qrm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire comp_t x,
    input  wire comp_t y,
    input  wire comp_t z,
    input  wire comp_t w,
    output logic       out_valid,
    input  wire logic  out_ready,
    output prod_t      prod
);

    logic                     valid_reg;
    prod_t                    prod_reg;
    prod_t                    prod_next;
    logic signed [PROD_W-1:0] xe, ye, ze, we;
    logic signed [PROD_W-1:0] sq_x, sq_y, sq_z, sq_w;

    assign xe = PROD_W'(x);
    assign ye = PROD_W'(y);
    assign ze = PROD_W'(z);
    assign we = PROD_W'(w);

    always_comb
    begin
        sq_x         = xe * xe;
        sq_y         = ye * ye;
        sq_z         = ze * ze;
        sq_w         = we * we;
        prod_next.xx = sq_x;
        prod_next.yy = sq_y;
        prod_next.zz = sq_z;
        prod_next.ww = sq_w;
        prod_next.xy = xe * ye;
        prod_next.xz = xe * ze;
        prod_next.yz = ye * ze;
        prod_next.wx = we * xe;
        prod_next.wy = we * ye;
        prod_next.wz = we * ze;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            prod_reg <= prod_next;
    end

    assign out_valid = valid_reg;
    assign prod      = prod_reg;

endmodule

`default_nettype wire

// ----- rtl/qrm_sum.sv -----
// Stage 2: sum of squares, the nine signed numerators and the length test.
// Depends on qrm_pkg.
`default_nettype none

module qrm_sum
    import qrm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire prod_t               prod,
    input  wire logic [EPS_SQ_W-1:0] eps_sq,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output norm_t                    norm,
    output num_t                     num [N_ELEM]
);

    logic  valid_reg;
    norm_t norm_reg;
    norm_t norm_next;
    num_t  num_reg  [N_ELEM];
    num_t  num_next [N_ELEM];
    num_t  xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;

    always_comb
    begin
        xx = NUM_W'(prod.xx);
        yy = NUM_W'(prod.yy);
        zz = NUM_W'(prod.zz);
        ww = NUM_W'(prod.ww);
        xy = NUM_W'(prod.xy);
        xz = NUM_W'(prod.xz);
        yz = NUM_W'(prod.yz);
        wx = NUM_W'(prod.wx);
        wy = NUM_W'(prod.wy);
        wz = NUM_W'(prod.wz);

        norm_next.s = SUM_W'(prod.xx) + SUM_W'(prod.yy) + SUM_W'(prod.zz) + SUM_W'(prod.ww);
        // length <= eps exactly when S <= eps^2; S = 0 is always caught
        norm_next.degen = (norm_next.s <= SUM_W'(eps_sq));

        num_next[E00] = xx + ww - yy - zz;
        num_next[E01] = (xy - wz) <<< 1;
        num_next[E02] = (xz + wy) <<< 1;
        num_next[E10] = (xy + wz) <<< 1;
        num_next[E11] = yy + ww - xx - zz;
        num_next[E12] = (yz - wx) <<< 1;
        num_next[E20] = (xz - wy) <<< 1;
        num_next[E21] = (yz + wx) <<< 1;
        num_next[E22] = zz + ww - xx - yy;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            norm_reg <= norm_next;
            num_reg  <= num_next;
        end
    end

    assign out_valid = valid_reg;
    assign norm      = norm_reg;
    assign num       = num_reg;

endmodule

`default_nettype wire

// ----- rtl/qrm_prep.sv -----
// Stage 3: splits each numerator into sign and magnitude and builds the
// rounding dividend |num|*2^(F+1) + S over the divisor 2*S. Depends on qrm_pkg.
`default_nettype none

module qrm_prep
    import qrm_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 14,
    parameter int R_W           = OUT_FRAC_BITS + 34
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire norm_t          norm,
    input  wire num_t           num     [N_ELEM],
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic                degen,
    output logic [D_W-1:0]      divisor,
    output logic [R_W-1:0]      rem     [N_ELEM],
    output logic [N_ELEM-1:0]   neg
);

    logic              valid_reg;
    logic              degen_reg;
    logic [D_W-1:0]    divisor_reg;
    logic [R_W-1:0]    rem_reg  [N_ELEM];
    logic [R_W-1:0]    rem_next [N_ELEM];
    logic [N_ELEM-1:0] neg_reg;
    logic [N_ELEM-1:0] neg_next;
    num_t              abs_v    [N_ELEM];

    always_comb
    begin
        for (int i = 0; i < N_ELEM; i++)
        begin
            neg_next[i] = num[i][NUM_W-1];
            abs_v[i]    = neg_next[i] ? -num[i] : num[i];
            rem_next[i] = (R_W'(abs_v[i][SUM_W-1:0]) << (OUT_FRAC_BITS + 1))
                        + R_W'(norm.s);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            degen_reg   <= norm.degen;
            divisor_reg <= {norm.s, 1'b0};
            rem_reg     <= rem_next;
            neg_reg     <= neg_next;
        end
    end

    assign out_valid = valid_reg;
    assign degen     = degen_reg;
    assign divisor   = divisor_reg;
    assign rem       = rem_reg;
    assign neg       = neg_reg;

endmodule

`default_nettype wire

// ----- rtl/qrm_div_step.sv -----
// One restoring division step for all nine elements: settles quotient bit BIT.
// Depends on qrm_pkg.
`default_nettype none

module qrm_div_step
    import qrm_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 14,
    parameter int R_W           = OUT_FRAC_BITS + 34,
    parameter int Q_W           = OUT_FRAC_BITS + 1,
    parameter int BIT           = 0
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              degen_in,
    input  wire logic [D_W-1:0]    divisor_in,
    input  wire logic [R_W-1:0]    rem_in   [N_ELEM],
    input  wire logic [Q_W-1:0]    quot_in  [N_ELEM],
    input  wire logic [N_ELEM-1:0] neg_in,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   degen_out,
    output logic [D_W-1:0]         divisor_out,
    output logic [R_W-1:0]         rem_out  [N_ELEM],
    output logic [Q_W-1:0]         quot_out [N_ELEM],
    output logic [N_ELEM-1:0]      neg_out
);

    logic              valid_reg;
    logic              degen_reg;
    logic [D_W-1:0]    divisor_reg;
    logic [R_W-1:0]    rem_reg   [N_ELEM];
    logic [R_W-1:0]    rem_next  [N_ELEM];
    logic [Q_W-1:0]    quot_reg  [N_ELEM];
    logic [Q_W-1:0]    quot_next [N_ELEM];
    logic [N_ELEM-1:0] neg_reg;
    logic [R_W:0]      dsh;
    logic [R_W:0]      trial     [N_ELEM];

    assign dsh = (R_W+1)'(divisor_in) << BIT;

    always_comb
    begin
        for (int i = 0; i < N_ELEM; i++)
        begin
            trial[i] = (R_W+1)'(rem_in[i]) - dsh;
            if (!trial[i][R_W])
            begin
                rem_next[i]  = trial[i][R_W-1:0];
                quot_next[i] = quot_in[i] | (Q_W'(1) << BIT);
            end
            else
            begin
                rem_next[i]  = rem_in[i];
                quot_next[i] = quot_in[i];
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            degen_reg   <= degen_in;
            divisor_reg <= divisor_in;
            rem_reg     <= rem_next;
            quot_reg    <= quot_next;
            neg_reg     <= neg_in;
        end
    end

    assign out_valid   = valid_reg;
    assign degen_out   = degen_reg;
    assign divisor_out = divisor_reg;
    assign rem_out     = rem_reg;
    assign quot_out    = quot_reg;
    assign neg_out     = neg_reg;

endmodule

`default_nettype wire

// ----- rtl/qrm_out.sv -----
// Last stage: saturate, restore sign, substitute identity when degenerate.
// Holds the output register. Depends on qrm_pkg.
`default_nettype none

module qrm_out
    import qrm_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 14,
    parameter int Q_W           = OUT_FRAC_BITS + 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              degen_in,
    input  wire logic [Q_W-1:0]    quot     [N_ELEM],
    input  wire logic [N_ELEM-1:0] neg,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output elem_t                  elem     [N_ELEM],
    output logic                   degen_out
);

    localparam int X_W = Q_W + OUT_W + 1;

    logic           valid_reg;
    logic           degen_reg;
    elem_t          elem_reg  [N_ELEM];
    elem_t          elem_next [N_ELEM];
    logic [X_W-1:0] one_x;
    logic [X_W-1:0] mag       [N_ELEM];
    logic [X_W-1:0] sgn       [N_ELEM];

    assign one_x = X_W'(1) << OUT_FRAC_BITS;

    always_comb
    begin
        for (int i = 0; i < N_ELEM; i++)
        begin
            mag[i] = (X_W'(quot[i]) > one_x) ? one_x : X_W'(quot[i]);
            sgn[i] = neg[i] ? (X_W'(0) - mag[i]) : mag[i];
            if (degen_in)
                elem_next[i] = (i % 4 == 0) ? one_x[OUT_W-1:0] : '0;
            else
                elem_next[i] = sgn[i][OUT_W-1:0];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            elem_reg  <= elem_next;
            degen_reg <= degen_in;
        end
    end

    assign out_valid = valid_reg;
    assign elem      = elem_reg;
    assign degen_out = degen_reg;

endmodule

`default_nettype wire

// ----- rtl/quaternion_to_rotation_matrix.sv -----
// Top level: quaternion (Q4.12) to normalised 3x3 rotation matrix (Q2.14).
// Depends on qrm_pkg, qrm_mult, qrm_sum, qrm_prep, qrm_div_step, qrm_out.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------
//   input    | in_valid / in_ready       | quat_x, quat_y, quat_z, quat_w
//   output   | out_valid / out_ready     | m00..m22, degenerate
//   config   | cfg_write_en (no wait)    | cfg_write_data -> length_epsilon
//
// One quaternion per cycle while out_ready holds. The pipeline registers are
// products, sums, dividend set-up, one stage per quotient bit of the shared
// divisor 2*S for all nine elements, and the output register.
// Every stage holds its own valid bit and loads whenever it is empty or its
// successor moves, so a stall at the output backs up without loss.
// Reset clears the valid bits and sets length_epsilon to 1; epsilon squared
// is registered from length_epsilon and follows a write in the cycle after.
`default_nettype none

module quaternion_to_rotation_matrix
    import qrm_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 14
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_en,
    input  wire logic [EPS_W-1:0]  cfg_write_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire comp_t             quat_x,
    input  wire comp_t             quat_y,
    input  wire comp_t             quat_z,
    input  wire comp_t             quat_w,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output elem_t                  m00,
    output elem_t                  m01,
    output elem_t                  m02,
    output elem_t                  m10,
    output elem_t                  m11,
    output elem_t                  m12,
    output elem_t                  m20,
    output elem_t                  m21,
    output elem_t                  m22,
    output logic                   degenerate
);

    localparam int R_W     = OUT_FRAC_BITS + 34;
    localparam int Q_W     = OUT_FRAC_BITS + 1;
    localparam int N_STEPS = Q_W;

    logic [EPS_W-1:0]    length_epsilon_reg;
    logic [EPS_SQ_W-1:0] eps_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_epsilon_reg <= EPS_W'(1);
            eps_sq_reg         <= EPS_SQ_W'(1);
        end
        else
        begin
            if (cfg_write_en)
                length_epsilon_reg <= cfg_write_data;
            eps_sq_reg <= EPS_SQ_W'(length_epsilon_reg) * EPS_SQ_W'(length_epsilon_reg);
        end
    end

    logic  mult_valid, mult_ready;
    prod_t prod;

    qrm_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x         (quat_x),
        .y         (quat_y),
        .z         (quat_z),
        .w         (quat_w),
        .out_valid (mult_valid),
        .out_ready (mult_ready),
        .prod      (prod)
    );

    logic  sum_valid, sum_ready;
    norm_t norm;
    num_t  num [N_ELEM];

    qrm_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mult_valid),
        .in_ready  (mult_ready),
        .prod      (prod),
        .eps_sq    (eps_sq_reg),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .norm      (norm),
        .num       (num)
    );

    // divider chain, index 0 is the set-up stage output
    logic              st_valid   [N_STEPS+1];
    logic              st_ready   [N_STEPS+1];
    logic              st_degen   [N_STEPS+1];
    logic [D_W-1:0]    st_divisor [N_STEPS+1];
    logic [R_W-1:0]    st_rem     [N_STEPS+1][N_ELEM];
    logic [Q_W-1:0]    st_quot    [N_STEPS+1][N_ELEM];
    logic [N_ELEM-1:0] st_neg     [N_STEPS+1];

    qrm_prep #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS),
        .R_W           (R_W)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .norm      (norm),
        .num       (num),
        .out_valid (st_valid[0]),
        .out_ready (st_ready[0]),
        .degen     (st_degen[0]),
        .divisor   (st_divisor[0]),
        .rem       (st_rem[0]),
        .neg       (st_neg[0])
    );

    always_comb
    begin
        for (int i = 0; i < N_ELEM; i++)
            st_quot[0][i] = '0;
    end

    for (genvar k = 0; k < N_STEPS; k++)
    begin : g_div
        qrm_div_step #(
            .OUT_FRAC_BITS (OUT_FRAC_BITS),
            .R_W           (R_W),
            .Q_W           (Q_W),
            .BIT           (Q_W - 1 - k)
        ) u_step (
            .clk         (clk),
            .rst_n       (rst_n),
            .in_valid    (st_valid[k]),
            .in_ready    (st_ready[k]),
            .degen_in    (st_degen[k]),
            .divisor_in  (st_divisor[k]),
            .rem_in      (st_rem[k]),
            .quot_in     (st_quot[k]),
            .neg_in      (st_neg[k]),
            .out_valid   (st_valid[k+1]),
            .out_ready   (st_ready[k+1]),
            .degen_out   (st_degen[k+1]),
            .divisor_out (st_divisor[k+1]),
            .rem_out     (st_rem[k+1]),
            .quot_out    (st_quot[k+1]),
            .neg_out     (st_neg[k+1])
        );
    end

    elem_t elem [N_ELEM];

    qrm_out #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS),
        .Q_W           (Q_W)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid[N_STEPS]),
        .in_ready  (st_ready[N_STEPS]),
        .degen_in  (st_degen[N_STEPS]),
        .quot      (st_quot[N_STEPS]),
        .neg       (st_neg[N_STEPS]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .elem      (elem),
        .degen_out (degenerate)
    );

    assign m00 = elem[E00];
    assign m01 = elem[E01];
    assign m02 = elem[E02];
    assign m10 = elem[E10];
    assign m11 = elem[E11];
    assign m12 = elem[E12];
    assign m20 = elem[E20];
    assign m21 = elem[E21];
    assign m22 = elem[E22];

endmodule

`default_nettype wire

// ----- rtl/qrm_checker.sv -----
// Port-level checks for the rotation matrix pipeline, bound to the top level.
// Depends on qrm_pkg.
`default_nettype none

module qrm_checker
    import qrm_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  in_ready,
    input wire logic  out_valid,
    input wire logic  out_ready,
    input wire elem_t m00,
    input wire elem_t m01,
    input wire elem_t m02,
    input wire elem_t m10,
    input wire elem_t m11,
    input wire elem_t m12,
    input wire elem_t m20,
    input wire elem_t m21,
    input wire elem_t m22,
    input wire logic  degenerate
);

    // a result held back must stay put (diagonal and degenerate flag checked)
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(m00) && $stable(m11)
                                    && $stable(m22) && $stable(degenerate))
        else $error("stalled result changed");

    // with nothing waiting at the output every stage can move
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_degen_offdiag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> m01 == '0 && m02 == '0 && m10 == '0
                                    && m12 == '0 && m20 == '0 && m21 == '0)
        else $error("degenerate result not diagonal");

    a_degen_diag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> m00 == m11 && m11 == m22)
        else $error("degenerate diagonal not uniform");

endmodule

bind quaternion_to_rotation_matrix qrm_checker u_qrm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .m00        (m00),
    .m01        (m01),
    .m02        (m02),
    .m10        (m10),
    .m11        (m11),
    .m12        (m12),
    .m20        (m20),
    .m21        (m21),
    .m22        (m22),
    .degenerate (degenerate)
);

`default_nettype wire
